@@ design/assert_macros.svh @@
// assertion helpers used by the top level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds on every clock edge outside reset
`define MRA_ASSERT_NOW(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// check that a condition implies another one in the same cycle
`define MRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/mra_pkg.sv @@
package mra_pkg;

    localparam int MAX_LEAVES_DEF = 1024;
    localparam int HASH_BITS_DEF  = 64;
    localparam int HT_W           = 4;
    localparam int PROOF_STEPS    = 17;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_PROVE  = 2'd1,
        KIND_VERIFY = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_IDX  = 2'd2,
        ST_RESERVED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_CHK,
        S_APP_SUM,
        S_PEAK_SCAN,
        S_PRV_LEAF,
        S_PRV_HT,
        S_PRV_R,
        S_PRV_L,
        S_PRV_END,
        S_VER_LEAF,
        S_VER_LOAD,
        S_VER_FOLD,
        S_VER_SCAN,
        S_VER_CMP
    } t_state;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] leaf_hash;
        logic [9:0]  leaf_index;
        logic [63:0] proof_hash;
        logic        proof_right;
        logic        has_element;
        logic        proof_last;
    } t_cmd;

    typedef struct packed {
        logic [63:0] out_hash;
        logic        out_right;
        logic [10:0] out_position;
        logic        item_present;
        logic        verified;
        logic [1:0]  status;
        logic        last;
    } t_result;

    // result with no payload: errors and empty runs
    function automatic t_result empty_result(t_status st);
        t_result r;
        r              = '0;
        r.status       = st;
        r.last         = 1'b1;
        return r;
    endfunction

endpackage

@@ design/mra_store.sv @@
module mra_store #(
    parameter int MAX_LEAVES = mra_pkg::MAX_LEAVES_DEF,
    parameter int HASH_BITS  = mra_pkg::HASH_BITS_DEF,
    localparam int NODE_DEPTH = 2 * MAX_LEAVES - 1,
    localparam int PW         = $clog2(2 * MAX_LEAVES),
    localparam int LAW        = $clog2(MAX_LEAVES)
) (
    input  logic                    i_clk,
    input  logic                    i_node_we,
    input  logic [PW-1:0]           i_node_waddr,
    input  logic [HASH_BITS-1:0]    i_node_whash,
    input  logic [mra_pkg::HT_W-1:0] i_node_wht,
    input  logic [PW-1:0]           i_node_raddr,
    output logic [HASH_BITS-1:0]    o_node_rhash,
    output logic [mra_pkg::HT_W-1:0] o_node_rht,
    input  logic                    i_leaf_we,
    input  logic [LAW-1:0]          i_leaf_waddr,
    input  logic [PW-1:0]           i_leaf_wdata,
    input  logic [LAW-1:0]          i_leaf_raddr,
    output logic [PW-1:0]           o_leaf_rdata
);

    // node hash and height side by side in one word
    logic [HASH_BITS+mra_pkg::HT_W-1:0] r_node_mem [NODE_DEPTH];
    logic [PW-1:0]                      r_leaf_mem [MAX_LEAVES];
    logic [HASH_BITS+mra_pkg::HT_W-1:0] r_node_rd;

    always_ff @(posedge i_clk) begin
        if (i_node_we) begin
            r_node_mem[i_node_waddr] <= {i_node_whash, i_node_wht};
        end
        r_node_rd <= r_node_mem[i_node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_leaf_we) begin
            r_leaf_mem[i_leaf_waddr] <= i_leaf_wdata;
        end
        o_leaf_rdata <= r_leaf_mem[i_leaf_raddr];
    end

    assign o_node_rhash = r_node_rd[HASH_BITS+mra_pkg::HT_W-1:mra_pkg::HT_W];
    assign o_node_rht   = r_node_rd[mra_pkg::HT_W-1:0];

endmodule

@@ design/mountain_range_accumulator_top.sv @@
// merkle mountain range accumulator
// command channel: i_cmd is taken at a clock edge where start is high and
// busy is low; kind selects append, prove or one verify element.
// result channel: o_strobe marks each result on o_result for one cycle;
// the receiver cannot hold results off, every strobe is a transaction.
// o_result.last marks the final result of one command.
// append: the accept writes the leaf, each merge takes a check and a sum
// step, a closing check follows, then the scan visits every bit of the leaf
// count while peaks stream out.
// prove: each level walked visits S_PRV_HT, then S_PRV_R, S_PRV_L or both,
// with one store read per cycle.
// verify: each element passes S_VER_LEAF, S_VER_LOAD on the first element
// only, and S_VER_FOLD; the final one adds a scan of the leaf count and a compare.
// every step is bounded by the single read port of the node store.
// reset clears counts and the verify run; the stores need no clearing pass
// since only written entries are ever read.
// results come out registered in r_out, behind the registered store read they need.
`include "assert_macros.svh"

module mountain_range_accumulator_top #(
    parameter int MAX_LEAVES = mra_pkg::MAX_LEAVES_DEF,
    parameter int HASH_BITS  = mra_pkg::HASH_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  mra_pkg::t_cmd    i_cmd,
    output logic             o_strobe,
    output mra_pkg::t_result o_result
);

    localparam int NODE_DEPTH = 2 * MAX_LEAVES - 1;
    localparam int PW  = $clog2(2 * MAX_LEAVES);       // node position
    localparam int LAW = $clog2(MAX_LEAVES);           // leaf address
    localparam int LCW = $clog2(MAX_LEAVES + 1);       // leaf count
    localparam int BW  = (LCW > 1) ? $clog2(LCW) : 1;  // bit index into count
    localparam int KW  = $clog2(LCW + 1);              // merge level
    localparam int EW  = ((PW > 16) ? PW : 16) + 2;    // offset arithmetic
    localparam int IXW = (LCW > 10) ? LCW : 10;        // index compare
    localparam int HT  = mra_pkg::HT_W;

    mra_pkg::t_state r_state, n_state;

    logic [LCW-1:0]       r_lc, n_lc;          // leaf count
    logic [PW-1:0]        r_nc, n_nc;          // node count
    logic [LCW-1:0]       r_old, n_old;        // leaf count before append
    logic [KW-1:0]        r_k, n_k;            // merge level
    logic [HASH_BITS-1:0] r_acc, n_acc;        // newest node hash
    logic [BW-1:0]        r_b, n_b;            // scan bit
    logic [PW:0]          r_s, n_s;            // scan running position + 1
    logic [PW-1:0]        r_pos, n_pos;        // walk position / chosen peak
    logic [HT-1:0]        r_h, n_h;
    logic [EW-1:0]        r_off, n_off;
    logic [4:0]           r_step, n_step;
    logic [HASH_BITS-1:0] r_run, n_run;        // verify running hash
    logic                 r_active, n_active;
    logic [PW-1:0]        r_lp, n_lp;          // verify leaf position
    logic                 r_has, n_has;
    logic [HASH_BITS-1:0] r_proof, n_proof;
    logic                 r_plast, n_plast;
    logic                 r_hold_v, n_hold_v;  // prove sibling awaiting its last flag
    mra_pkg::t_result     r_hold, n_hold;
    logic                 r_pend, n_pend;      // peak read in flight
    logic [PW-1:0]        r_pend_pos, n_pend_pos;
    logic                 r_pend_last, n_pend_last;
    logic                 r_out_v;
    mra_pkg::t_result     r_out;

    logic                 fsm_v;
    mra_pkg::t_result     fsm_out;
    mra_pkg::t_result     pend_out;            // peak result built from the store read

    // assertion terms
    logic                 err_out;
    logic                 err_lone;
    logic                 pend_ok;

    // store ports
    logic                 node_we;
    logic [PW-1:0]        node_waddr;
    logic [HASH_BITS-1:0] node_whash;
    logic [HT-1:0]        node_wht;
    logic [PW-1:0]        node_raddr;
    logic [HASH_BITS-1:0] node_rhash;
    logic [HT-1:0]        node_rht;
    logic                 leaf_we;
    logic [LAW-1:0]       leaf_waddr;
    logic [PW-1:0]        leaf_wdata;
    logic [LAW-1:0]       leaf_raddr;
    logic [PW-1:0]        leaf_rdata;

    mra_store #(
        .MAX_LEAVES(MAX_LEAVES),
        .HASH_BITS (HASH_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_node_we   (node_we),
        .i_node_waddr(node_waddr),
        .i_node_whash(node_whash),
        .i_node_wht  (node_wht),
        .i_node_raddr(node_raddr),
        .o_node_rhash(node_rhash),
        .o_node_rht  (node_rht),
        .i_leaf_we   (leaf_we),
        .i_leaf_waddr(leaf_waddr),
        .i_leaf_wdata(leaf_wdata),
        .i_leaf_raddr(leaf_raddr),
        .o_leaf_rdata(leaf_rdata)
    );

    logic                 accept;
    logic                 idx_bad;
    logic [HASH_BITS-1:0] add_a, add_b, add_sum;   // shared hash adder
    logic                 scan_bit;
    logic [PW:0]          scan_s_new;
    logic [PW-1:0]        scan_p;
    logic                 scan_low_zero;
    logic [EW-1:0]        pos_e, nc_e, new_pos;

    assign accept  = start && !busy;
    assign idx_bad = IXW'(i_cmd.leaf_index) >= IXW'(r_lc);
    assign add_sum = add_a + add_b;

    // peak walk over the set bits of the leaf count, highest first
    assign scan_bit      = r_lc[r_b];
    assign scan_s_new    = r_s + (((PW+1)'(1) << (r_b + 1'b1)) - (PW+1)'(1));
    assign scan_p        = PW'(scan_s_new - (PW+1)'(1));
    assign scan_low_zero = (r_lc & ((LCW'(1) << r_b) - LCW'(1))) == '0;

    assign pos_e = EW'(r_pos);
    assign nc_e  = EW'(r_nc);

    always_comb begin
        n_state     = r_state;
        n_lc        = r_lc;
        n_nc        = r_nc;
        n_old       = r_old;
        n_k         = r_k;
        n_acc       = r_acc;
        n_b         = r_b;
        n_s         = r_s;
        n_pos       = r_pos;
        n_h         = r_h;
        n_off       = r_off;
        n_step      = r_step;
        n_run       = r_run;
        n_active    = r_active;
        n_lp        = r_lp;
        n_has       = r_has;
        n_proof     = r_proof;
        n_plast     = r_plast;
        n_hold_v    = r_hold_v;
        n_hold      = r_hold;
        n_pend      = 1'b0;
        n_pend_pos  = r_pend_pos;
        n_pend_last = r_pend_last;
        fsm_v       = 1'b0;
        fsm_out     = mra_pkg::empty_result(mra_pkg::ST_OK);
        node_we     = 1'b0;
        node_waddr  = r_nc;
        node_whash  = i_cmd.leaf_hash[HASH_BITS-1:0];
        node_wht    = '0;
        node_raddr  = r_pos;
        leaf_we     = 1'b0;
        leaf_waddr  = LAW'(r_lc);
        leaf_wdata  = r_nc;
        leaf_raddr  = LAW'(i_cmd.leaf_index);
        add_a       = r_acc;
        add_b       = node_rhash;
        new_pos     = '0;

        unique case (r_state)
            mra_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (mra_pkg::t_kind'(i_cmd.kind))
                        mra_pkg::KIND_APPEND: begin
                            if (r_lc >= LCW'(MAX_LEAVES) || r_nc >= PW'(NODE_DEPTH)) begin
                                fsm_v   = 1'b1;
                                fsm_out = mra_pkg::empty_result(mra_pkg::ST_FULL);
                            end else begin
                                node_we  = 1'b1;
                                leaf_we  = 1'b1;
                                n_nc     = r_nc + 1'b1;
                                n_acc    = i_cmd.leaf_hash[HASH_BITS-1:0];
                                n_old    = r_lc;
                                n_k      = '0;
                                n_state  = mra_pkg::S_APP_CHK;
                            end
                        end
                        mra_pkg::KIND_PROVE: begin
                            if (idx_bad) begin
                                fsm_v   = 1'b1;
                                fsm_out = mra_pkg::empty_result(mra_pkg::ST_BAD_IDX);
                            end else begin
                                n_step   = '0;
                                n_hold_v = 1'b0;
                                n_state  = mra_pkg::S_PRV_LEAF;
                            end
                        end
                        mra_pkg::KIND_VERIFY: begin
                            if (idx_bad) begin
                                n_active = 1'b0;
                                fsm_v    = 1'b1;
                                fsm_out  = mra_pkg::empty_result(mra_pkg::ST_BAD_IDX);
                            end else begin
                                n_has   = i_cmd.has_element;
                                n_proof = i_cmd.proof_hash[HASH_BITS-1:0];
                                n_plast = i_cmd.proof_last;
                                n_state = mra_pkg::S_VER_LEAF;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // merge while the two newest mountains have equal height
            mra_pkg::S_APP_CHK: begin
                if (KW'(LCW) > r_k && r_old[BW'(r_k)] && r_nc < PW'(NODE_DEPTH)) begin
                    node_raddr = r_nc - (PW'(1) << (r_k + 1'b1));
                    n_state    = mra_pkg::S_APP_SUM;
                end else begin
                    n_lc    = r_lc + 1'b1;
                    n_b     = BW'(LCW - 1);
                    n_s     = '0;
                    n_state = mra_pkg::S_PEAK_SCAN;
                end
            end

            mra_pkg::S_APP_SUM: begin
                node_we    = 1'b1;
                node_whash = add_sum;
                node_wht   = HT'(r_k + 1'b1);
                n_acc      = add_sum;
                n_nc       = r_nc + 1'b1;
                n_k        = r_k + 1'b1;
                n_state    = mra_pkg::S_APP_CHK;
            end

            mra_pkg::S_PEAK_SCAN: begin
                if (scan_bit) begin
                    n_s         = scan_s_new;
                    node_raddr  = scan_p;
                    n_pend      = 1'b1;
                    n_pend_pos  = scan_p;
                    n_pend_last = scan_low_zero;
                end
                if (r_b == '0) begin
                    n_state = mra_pkg::S_IDLE;
                end else begin
                    n_b = r_b - 1'b1;
                end
            end

            mra_pkg::S_PRV_LEAF: begin
                n_pos      = leaf_rdata;
                node_raddr = leaf_rdata;
                n_state    = mra_pkg::S_PRV_HT;
            end

            // sibling lies one mountain of this height to the right or left
            mra_pkg::S_PRV_HT: begin
                n_h   = node_rht;
                n_off = (EW'(1) << (node_rht + 1'b1)) - EW'(1);
                if (pos_e + n_off < nc_e) begin
                    node_raddr = PW'(pos_e + n_off);
                    n_state    = mra_pkg::S_PRV_R;
                end else if (pos_e >= n_off) begin
                    node_raddr = PW'(pos_e - n_off);
                    n_state    = mra_pkg::S_PRV_L;
                end else begin
                    n_state = mra_pkg::S_PRV_END;
                end
            end

            mra_pkg::S_PRV_R, mra_pkg::S_PRV_L: begin
                if (node_rht == r_h) begin
                    // release the previous sibling, hold this one
                    fsm_v                = r_hold_v;
                    fsm_out              = r_hold;
                    fsm_out.last         = 1'b0;
                    n_hold_v             = 1'b1;
                    n_hold               = '0;
                    n_hold.out_hash      = 64'(node_rhash);
                    n_hold.item_present  = 1'b1;
                    if (r_state == mra_pkg::S_PRV_R) begin
                        n_hold.out_right    = 1'b1;
                        n_hold.out_position = 11'(pos_e + r_off);
                        new_pos             = pos_e + r_off + EW'(1);
                    end else begin
                        n_hold.out_position = 11'(pos_e - r_off);
                        new_pos             = pos_e + EW'(1);
                    end
                    n_step     = r_step + 1'b1;
                    n_pos      = PW'(new_pos);
                    node_raddr = PW'(new_pos);
                    if (new_pos >= nc_e || n_step == 5'(mra_pkg::PROOF_STEPS)) begin
                        n_state = mra_pkg::S_PRV_END;
                    end else begin
                        n_state = mra_pkg::S_PRV_HT;
                    end
                end else if (r_state == mra_pkg::S_PRV_R && pos_e >= r_off) begin
                    node_raddr = PW'(pos_e - r_off);
                    n_state    = mra_pkg::S_PRV_L;
                end else begin
                    n_state = mra_pkg::S_PRV_END;
                end
            end

            mra_pkg::S_PRV_END: begin
                fsm_v = 1'b1;
                if (r_hold_v) begin
                    fsm_out      = r_hold;
                    fsm_out.last = 1'b1;
                end
                n_hold_v = 1'b0;
                n_state  = mra_pkg::S_IDLE;
            end

            mra_pkg::S_VER_LEAF: begin
                n_lp       = leaf_rdata;
                node_raddr = leaf_rdata;
                n_state    = r_active ? mra_pkg::S_VER_FOLD : mra_pkg::S_VER_LOAD;
            end

            mra_pkg::S_VER_LOAD: begin
                n_run    = node_rhash;
                n_active = 1'b1;
                n_state  = mra_pkg::S_VER_FOLD;
            end

            mra_pkg::S_VER_FOLD: begin
                add_a = r_run;
                add_b = r_proof;
                if (r_has) begin
                    n_run = add_sum;
                end
                if (r_plast) begin
                    n_active = 1'b0;
                    n_b      = BW'(LCW - 1);
                    n_s      = '0;
                    n_state  = mra_pkg::S_VER_SCAN;
                end else begin
                    n_state = mra_pkg::S_IDLE;
                end
            end

            // first peak at or after the leaf, else the smallest peak
            mra_pkg::S_VER_SCAN: begin
                if (scan_bit) begin
                    n_s = scan_s_new;
                    if (scan_p >= r_lp || scan_low_zero) begin
                        node_raddr = scan_p;
                        n_pos      = scan_p;
                        n_state    = mra_pkg::S_VER_CMP;
                    end
                end
                n_b = r_b - 1'b1;
            end

            mra_pkg::S_VER_CMP: begin
                fsm_v                = 1'b1;
                fsm_out.out_hash     = 64'(r_run);
                fsm_out.out_position = 11'(r_pos);
                fsm_out.item_present = 1'b1;
                fsm_out.verified     = (r_run == node_rhash);
                n_state              = mra_pkg::S_IDLE;
            end

            default: begin
                n_state = mra_pkg::S_IDLE;
            end
        endcase
    end

    // peak result once its store read has returned
    always_comb begin
        pend_out              = '0;
        pend_out.out_hash     = 64'(node_rhash);
        pend_out.out_position = 11'(r_pend_pos);
        pend_out.item_present = 1'b1;
        pend_out.last         = r_pend_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mra_pkg::S_IDLE;
            r_lc     <= '0;
            r_nc     <= '0;
            r_run    <= '0;
            r_active <= 1'b0;
            r_hold_v <= 1'b0;
            r_pend   <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lc     <= n_lc;
            r_nc     <= n_nc;
            r_run    <= n_run;
            r_active <= n_active;
            r_hold_v <= n_hold_v;
            r_pend   <= n_pend;
            r_out_v  <= r_pend || fsm_v;
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        r_old       <= n_old;
        r_k         <= n_k;
        r_acc       <= n_acc;
        r_b         <= n_b;
        r_s         <= n_s;
        r_pos       <= n_pos;
        r_h         <= n_h;
        r_off       <= n_off;
        r_step      <= n_step;
        r_lp        <= n_lp;
        r_has       <= n_has;
        r_proof     <= n_proof;
        r_plast     <= n_plast;
        r_hold      <= n_hold;
        r_pend_pos  <= n_pend_pos;
        r_pend_last <= n_pend_last;
        r_out       <= r_pend ? pend_out : fsm_out;
    end

    assign busy     = (r_state != mra_pkg::S_IDLE) || r_pend;
    assign o_strobe = r_out_v;
    assign o_result = r_out;

    assign err_out  = o_strobe && (o_result.status != mra_pkg::ST_OK);
    assign err_lone = o_result.last && !o_result.item_present;
    assign pend_ok  = (r_state == mra_pkg::S_PEAK_SCAN) || (r_state == mra_pkg::S_IDLE);

    `MRA_ASSERT_NOW(a_nodes_cover_leaves, (PW+1)'(r_nc) >= (PW+1)'(r_lc), "too few nodes")
    `MRA_ASSERT_IMP(a_error_is_final, err_out, err_lone, "error result not lone and final")
    `MRA_ASSERT_IMP(a_pend_in_append, r_pend, pend_ok, "peak read outside append")

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAVES = 1024;
    localparam int NODES  = 2 * LEAVES - 1;
    localparam int WATCHDOG_LIMIT = 3000;

    // mirror of the mountain range store, updated once per accepted transaction
    class mountain_predictor;
        logic [63:0] node_hash [NODES];
        logic [3:0]  node_height [NODES];
        int unsigned leaf_pos [LEAVES];
        int unsigned leaf_total;
        int unsigned node_total;
        logic [63:0] fold_hash;
        bit          fold_open;
        mra_pkg::t_result expected_results[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function void clear();
            foreach (node_hash[i]) begin
                node_hash[i] = '0;
                node_height[i] = '0;
            end
            foreach (leaf_pos[i]) leaf_pos[i] = 0;
            leaf_total = 0;
            node_total = 0;
            fold_hash = '0;
            fold_open = 0;
            expected_results.delete();
            mismatches = 0;
            results_seen = 0;
        endfunction

        function int unsigned msb_index(int unsigned n);
            int unsigned b;
            b = 0;
            while (b < 31 && (n >> (b + 1)) != 0) b++;
            return b;
        endfunction

        function void push(logic [63:0] h, bit right, int unsigned pos, bit present,
                           bit ok, mra_pkg::t_status st, bit fin);
            mra_pkg::t_result r;
            r = '0;
            r.out_hash = h;
            r.out_right = right;
            r.out_position = pos[10:0];
            r.item_present = present;
            r.verified = ok;
            r.status = st;
            r.last = fin;
            expected_results = {expected_results, r};
        endfunction

        function void mark_last();
            mra_pkg::t_result r;
            r = expected_results.pop_back();
            r.last = 1'b1;
            expected_results = {expected_results, r};
        endfunction

        // first peak at or beyond the leaf's node position
        function int unsigned covering_peak(int unsigned n, int unsigned lp);
            int unsigned hb, pos;
            hb = msb_index(n);
            pos = (1 << (hb + 1)) - 2;
            if (pos >= lp) return pos;
            for (int unsigned j = hb; j > 0; j--) begin
                if ((n >> (j - 1)) & 1) begin
                    pos += (1 << j) - 1;
                    if (pos >= lp) return pos;
                end
            end
            return pos;
        endfunction

        // sibling hashes on the path from a leaf to its peak
        function void sibling_path(int unsigned idx, ref logic [63:0] sibs[$],
                                   ref bit sides[$], ref int unsigned spos[$]);
            int unsigned pos, h, off;
            sibs.delete();
            sides.delete();
            spos.delete();
            pos = leaf_pos[idx];
            for (int s = 0; s < mra_pkg::PROOF_STEPS; s++) begin
                h = node_height[pos];
                off = (1 << (h + 1)) - 1;
                if (pos + off < node_total && node_height[pos + off] == h) begin
                    sibs = {sibs, node_hash[pos + off]};
                    sides = {sides, 1'b1};
                    spos = {spos, pos + off};
                    pos = pos + off + 1;
                end else if (pos >= off && node_height[pos - off] == h) begin
                    sibs = {sibs, node_hash[pos - off]};
                    sides = {sides, 1'b0};
                    spos = {spos, pos - off};
                    pos = pos + 1;
                end else begin
                    break;
                end
                if (pos >= node_total) break;
            end
        endfunction

        function void note_command(mra_pkg::t_cmd c);
            int unsigned prior, hb, pos, lp, r, l;
            logic [63:0] sibs[$];
            bit sides[$];
            int unsigned spos[$];
            case (mra_pkg::t_kind'(c.kind))
                mra_pkg::KIND_APPEND: begin
                    if (leaf_total >= LEAVES || node_total >= NODES) begin
                        push('0, 0, 0, 0, 0, mra_pkg::ST_FULL, 1);
                        return;
                    end
                    prior = leaf_total;
                    node_hash[node_total] = c.leaf_hash;
                    node_height[node_total] = '0;
                    leaf_pos[leaf_total] = node_total;
                    node_total++;
                    for (int unsigned k = 0; k < 31 && ((prior >> k) & 1) &&
                         node_total < NODES; k++) begin
                        r = node_total - 1;
                        l = r - ((1 << (k + 1)) - 1);
                        node_hash[node_total] = node_hash[l] + node_hash[r];
                        node_height[node_total] = 4'(k + 1);
                        node_total++;
                    end
                    leaf_total++;
                    // peaks, tallest first
                    hb = msb_index(leaf_total);
                    pos = (1 << (hb + 1)) - 2;
                    push(node_hash[pos], 0, pos, 1, 0, mra_pkg::ST_OK, 0);
                    for (int unsigned j = hb; j > 0; j--) begin
                        if ((leaf_total >> (j - 1)) & 1) begin
                            pos += (1 << j) - 1;
                            push(node_hash[pos], 0, pos, 1, 0, mra_pkg::ST_OK, 0);
                        end
                    end
                    mark_last();
                end
                mra_pkg::KIND_PROVE: begin
                    if (c.leaf_index >= leaf_total) begin
                        push('0, 0, 0, 0, 0, mra_pkg::ST_BAD_IDX, 1);
                        return;
                    end
                    sibling_path(c.leaf_index, sibs, sides, spos);
                    if (sibs.size() == 0) begin
                        push('0, 0, 0, 0, 0, mra_pkg::ST_OK, 1);
                        return;
                    end
                    foreach (sibs[i])
                        push(sibs[i], sides[i], spos[i], 1, 0, mra_pkg::ST_OK, 0);
                    mark_last();
                end
                mra_pkg::KIND_VERIFY: begin
                    if (c.leaf_index >= leaf_total) begin
                        fold_open = 0;
                        push('0, 0, 0, 0, 0, mra_pkg::ST_BAD_IDX, 1);
                        return;
                    end
                    lp = leaf_pos[c.leaf_index];
                    if (!fold_open) begin
                        fold_hash = node_hash[lp];
                        fold_open = 1;
                    end
                    if (c.has_element) fold_hash = fold_hash + c.proof_hash;
                    if (!c.proof_last) return;
                    fold_open = 0;
                    pos = covering_peak(leaf_total, lp);
                    push(fold_hash, 0, pos, 1, fold_hash == node_hash[pos], mra_pkg::ST_OK, 1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(mra_pkg::t_result got);
            mra_pkg::t_result want;
            bit bad;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = expected_results.pop_front();
            bad = (got.out_hash !== want.out_hash) || (got.out_right !== want.out_right) ||
                  (got.out_position !== want.out_position) ||
                  (got.item_present !== want.item_present) ||
                  (got.verified !== want.verified) || (got.status !== want.status) ||
                  (got.last !== want.last);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch at %0t\n  expected %p\n  actual   %p",
                             $realtime, want, got);
            end
        endfunction
    endclass

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    mra_pkg::t_cmd    i_cmd;
    logic    o_strobe;
    mra_pkg::t_result o_result;

    mountain_range_accumulator_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    mountain_predictor model;
    int unsigned idle_pct;
    int unsigned sent_count;
    int unsigned stall_cycles;
    int unsigned verify_runs;
    bit          accept_seen;

    // 20 ns clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // every strobe is a transaction; the receiver never holds off
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) model.check_result(o_result);
    end

    // watchdog: cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || accept_seen || o_strobe === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired, %0d results still pending",
                         model.expected_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one command transaction, with a random gap in front when idling is on
    task automatic send(mra_pkg::t_cmd c);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        accept_seen = 0;
        do @(posedge i_clk); while (busy !== 1'b0);
        accept_seen = 1;
        model.note_command(c);
        if (c.kind != mra_pkg::KIND_NONE) sent_count++;
    endtask

    function automatic mra_pkg::t_cmd make_cmd(mra_pkg::t_kind k, logic [9:0] idx);
        mra_pkg::t_cmd c;
        c = '0;
        c.kind = k;
        c.leaf_index = idx;
        return c;
    endfunction

    task automatic append_leaf(logic [63:0] h);
        mra_pkg::t_cmd c;
        c = make_cmd(mra_pkg::KIND_APPEND, '0);
        c.leaf_hash = h;
        c.proof_hash = rand64();
        send(c);
    endtask

    task automatic prove_leaf(logic [9:0] idx);
        mra_pkg::t_cmd c;
        c = make_cmd(mra_pkg::KIND_PROVE, idx);
        c.leaf_hash = rand64();
        send(c);
    endtask

    // a well formed verify run built from the current tree, optionally spoiled
    task automatic verify_leaf(logic [9:0] idx, bit spoil, bit lead_empty);
        logic [63:0] sibs[$];
        bit sides[$];
        int unsigned spos[$];
        mra_pkg::t_cmd c;
        int n;
        model.sibling_path(idx, sibs, sides, spos);
        if (spoil && sibs.size() > 0) sibs[$urandom_range(sibs.size() - 1)] ^= rand64() | 1;
        verify_runs++;
        if (lead_empty || sibs.size() == 0) begin
            c = make_cmd(mra_pkg::KIND_VERIFY, idx);
            c.proof_hash = rand64();
            c.proof_last = (sibs.size() == 0);
            send(c);
        end
        n = sibs.size();
        for (int i = 0; i < n; i++) begin
            c = make_cmd(mra_pkg::KIND_VERIFY, idx);
            c.proof_hash = sibs[i];
            c.proof_right = sides[i];
            c.has_element = 1'b1;
            c.proof_last = (i == n - 1);
            c.leaf_hash = rand64();
            send(c);
        end
    endtask

    // noise: loose verify pieces, stray indices, unknown kind
    task automatic noise_item();
        mra_pkg::t_cmd c;
        c = '0;
        c.kind = mra_pkg::t_kind'($urandom_range(3));
        c.leaf_hash = rand64();
        c.proof_hash = rand64();
        c.leaf_index = $urandom_range(1023);
        c.proof_right = $urandom_range(1);
        c.has_element = $urandom_range(1);
        c.proof_last = $urandom_range(1);
        if (c.kind == mra_pkg::KIND_APPEND) c.kind = mra_pkg::KIND_VERIFY;
        send(c);
    endtask

    task automatic random_item();
        int unsigned pick;
        logic [9:0] idx;
        pick = $urandom_range(99);
        idx = (model.leaf_total > 0) ? 10'($urandom_range(model.leaf_total - 1)) : '0;
        if (pick < 40 || model.leaf_total == 0) begin
            append_leaf(rand64());
        end else if (pick < 60) begin
            prove_leaf($urandom_range(9) == 0 ? 10'($urandom_range(1023)) : idx);
        end else if (pick < 88) begin
            verify_leaf(idx, $urandom_range(4) == 0, $urandom_range(3) == 0);
        end else begin
            noise_item();
        end
    endtask

    // stop sending and wait for every expected result
    task automatic drain();
        start <= 1'b0;
        accept_seen = 0;
        while (model.expected_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        mra_pkg::t_cmd c;
        model = new();
        model.clear();
        idle_pct = 0;
        sent_count = 0;
        verify_runs = 0;
        stall_cycles = 0;
        accept_seen = 0;
        start = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store errors, lone peak, extremes, interleaving
        prove_leaf('0);
        c = make_cmd(mra_pkg::KIND_VERIFY, 10'h3ff);
        c.proof_last = 1'b1;
        send(c);
        append_leaf('1);
        prove_leaf('0);
        verify_leaf('0, 0, 0);
        append_leaf('1);
        append_leaf('0);
        append_leaf(64'h8000_0000_0000_0001);
        prove_leaf(10'd3);
        prove_leaf(10'd4);
        prove_leaf(10'h3ff);
        verify_leaf(10'd1, 0, 1);
        verify_leaf(10'd2, 1, 0);
        // verify run opened, interrupted by an append, then closed
        c = make_cmd(mra_pkg::KIND_VERIFY, 10'd0);
        c.has_element = 1'b1;
        c.proof_hash = '1;
        send(c);
        append_leaf(64'h0123_4567_89ab_cdef);
        c.has_element = 1'b0;
        c.proof_last = 1'b1;
        c.leaf_index = 10'd4;
        send(c);
        // verify run broken by a bad index
        c = make_cmd(mra_pkg::KIND_VERIFY, 10'd1);
        c.has_element = 1'b1;
        c.proof_hash = 64'd5;
        send(c);
        c.leaf_index = 10'd200;
        send(c);
        c = make_cmd(mra_pkg::KIND_NONE, 10'h3ff);
        c.leaf_hash = '1;
        c.proof_hash = '1;
        c.proof_right = 1'b1;
        c.has_element = 1'b1;
        c.proof_last = 1'b1;
        send(c);
        drain();

        // random traffic in four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 59;
                2: idle_pct = 0;
                default: idle_pct = 38;
            endcase
            while (sent_count < 25 + 70 * (ph + 1)) random_item();
        end

        // closing mix: two more leaves, then indices at and past the top
        idle_pct = 0;
        append_leaf(rand64());
        append_leaf('1);
        idle_pct = 38;
        prove_leaf(10'h3ff);
        prove_leaf('0);
        verify_leaf(10'h3ff, 0, 0);
        verify_leaf(10'h2aa, 0, 1);
        verify_leaf(10'h155, 1, 0);
        start <= 1'b0;
        accept_seen = 0;

        drain();
        repeat (60) @(posedge i_clk);
        $display("ran %0d commands (%0d verify runs), checked %0d results",
                 sent_count, verify_runs, model.results_seen);
        $display("store grew to %0d leaves; %0d mismatches, %0d results never arrived",
                 model.leaf_total, model.mismatches, model.expected_results.size());
        if (model.mismatches == 0 && model.expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
